// ----- design/trimmed_mean_threshold_detector_unit_macros.svh -----
// Assertion macros for the trimmed-mean threshold detector.
// Used by design/trimmed_mean_threshold_detector_unit.sv; expects clk and arst_n in scope.
`ifndef TRIMMED_MEAN_THRESHOLD_DETECTOR_UNIT_MACROS_SVH
`define TRIMMED_MEAN_THRESHOLD_DETECTOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked only while out of reset
`define TMTD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define TMTD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TMTD_ASSERT(lbl, prop, msg)
`define TMTD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- design/tmtd_pkg.sv -----
// Shared types and constants of the trimmed-mean threshold detector.
// No dependencies; used by trimmed_mean_threshold_detector_unit.
package tmtd_pkg;

	localparam int SAMPLE_W    = 12;
	localparam int MEAN_W      = 12;
	localparam int TICK_W      = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int TRIM_SLOTS  = 4;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_DETECT_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_REPORT_HOLDOFF   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MEASURE_ENABLE   = 2'd2;

	localparam logic [TICK_W-1:0] HOLDOFF_RESET = 16'd1000;
	localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;
	localparam logic [MEAN_W-1:0] MEAN_MAX      = 12'hFFF;

	// item kinds
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	// what travels down the pipeline behind the input register
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_TICK  = 2'd1;
	localparam logic [1:0] KIND_BLOCK = 2'd2;

	typedef struct packed {
		logic                func;
		logic [SAMPLE_W-1:0] sample_value;
	} req_t;

	typedef struct packed {
		logic [MEAN_W-1:0] trimmed_mean;
		logic              detected;
		logic              report;
	} rsp_t;

endpackage

// ----- design/trimmed_mean_threshold_detector_unit.sv -----
// Trimmed-mean threshold detector: top level.
// Depends on tmtd_pkg and trimmed_mean_threshold_detector_unit_macros.svh.

// Takes one item (sample or tick) per cycle on req while req_ready is high, and gives a
// result on rsp only when a sample closes a block of BLOCK_SIZE samples. Items move
// through a four-register pipeline (input register, block collection, trim subtraction,
// reciprocal multiply with threshold and holdoff check) into the rsp output register;
// the whole pipeline holds while that register waits to be taken, so throughput is one
// item per cycle whenever rsp_ready is high.
// Ticks are counted in the last stage, in order with the block results.
// Configuration writes are taken in any cycle (cfg_ready is always high).
`include "trimmed_mean_threshold_detector_unit_macros.svh"

module trimmed_mean_threshold_detector_unit #(
	parameter int BLOCK_SIZE  = 14,
	parameter int TRIM_LOW    = 2,
	parameter int TRIM_HIGH   = 2,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  tmtd_pkg::req_t                    req_data,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output tmtd_pkg::rsp_t                    rsp_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tmtd_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tmtd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int VBITS  = (SAMPLE_BITS < tmtd_pkg::SAMPLE_W) ? SAMPLE_BITS : tmtd_pkg::SAMPLE_W;
	localparam int CNT_W  = $clog2(BLOCK_SIZE);
	localparam int SUM_W  = VBITS + $clog2(BLOCK_SIZE);
	localparam int DIV_N  = BLOCK_SIZE - TRIM_LOW - TRIM_HIGH;
	localparam int DIV    = (DIV_N > 0) ? DIV_N : 1;
	localparam int DIV_SH = SUM_W + $clog2(DIV);
	localparam int RECIP_W = DIV_SH + 1;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam longint unsigned RECIP = ((64'd1 << DIV_SH) + 64'(DIV) - 64'd1) / 64'(DIV);
	localparam logic [RECIP_W-1:0] RECIP_K = RECIP_W'(RECIP);
	localparam logic [CNT_W-1:0]   LAST_CNT = CNT_W'(BLOCK_SIZE - 1);

	// configuration
	logic [tmtd_pkg::MEAN_W-1:0] threshold_q;
	logic [tmtd_pkg::TICK_W-1:0] holdoff_q;
	logic                        enable_q;

	// block collection state
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic [VBITS-1:0] lows_q  [tmtd_pkg::TRIM_SLOTS];
	logic [VBITS-1:0] highs_q [tmtd_pkg::TRIM_SLOTS];
	logic [tmtd_pkg::TICK_W-1:0] ticks_q;

	// pipeline
	logic           en;
	logic           valid_s1;
	tmtd_pkg::req_t req_s1;
	logic [1:0]       kind_s2;
	logic [SUM_W-1:0] sum_s2;
	logic [VBITS-1:0] lows_s2  [tmtd_pkg::TRIM_SLOTS];
	logic [VBITS-1:0] highs_s2 [tmtd_pkg::TRIM_SLOTS];
	logic [1:0]       kind_s3;
	logic [SUM_W-1:0] trim_s3;
	logic             rsp_valid_q;
	tmtd_pkg::rsp_t   rsp_data_q;

	// stage 1 logic
	logic             is_tick;
	logic             is_sample;
	logic             last;
	logic [VBITS-1:0] v;
	logic [SUM_W-1:0] sum_nxt;
	logic [VBITS-1:0] lows_nxt  [tmtd_pkg::TRIM_SLOTS];
	logic [VBITS-1:0] highs_nxt [tmtd_pkg::TRIM_SLOTS];

	// stage 2 / 3 logic
	logic [SUM_W-1:0]  total;
	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] quot;
	logic [tmtd_pkg::MEAN_W-1:0] mean;
	logic              detected_w;
	logic              report_w;

	assign en        = !rsp_valid_q || rsp_ready;
	assign req_ready = en;
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			holdoff_q   <= tmtd_pkg::HOLDOFF_RESET;
			enable_q    <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				tmtd_pkg::REG_DETECT_THRESHOLD: threshold_q <= cfg_data[tmtd_pkg::MEAN_W-1:0];
				tmtd_pkg::REG_REPORT_HOLDOFF:   holdoff_q   <= cfg_data[tmtd_pkg::TICK_W-1:0];
				tmtd_pkg::REG_MEASURE_ENABLE:   enable_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && req_valid) begin
			req_s1 <= req_data;
		end
	end

	// stage 1: sorted insert into the low and high trim lists, running sum
	always_comb begin
		is_tick   = valid_s1 && (req_s1.func == tmtd_pkg::FUNC_TICK);
		is_sample = valid_s1 && (req_s1.func == tmtd_pkg::FUNC_SAMPLE) && enable_q;
		last      = is_sample && (count_q == LAST_CNT);
		v         = req_s1.sample_value[VBITS-1:0];
		sum_nxt   = sum_q + SUM_W'(v);
		for (int i = 0; i < tmtd_pkg::TRIM_SLOTS; i++) begin
			lows_nxt[i]  = lows_q[i];
			highs_nxt[i] = highs_q[i];
			// entries strictly beyond v shift one place out; v lands at the first of them
			if (i < TRIM_LOW && lows_q[i] > v) begin
				if (i > 0 && lows_q[(i > 0) ? i - 1 : 0] > v) begin
					lows_nxt[i] = lows_q[(i > 0) ? i - 1 : 0];
				end else begin
					lows_nxt[i] = v;
				end
			end
			if (i < TRIM_HIGH && highs_q[i] < v) begin
				if (i > 0 && highs_q[(i > 0) ? i - 1 : 0] < v) begin
					highs_nxt[i] = highs_q[(i > 0) ? i - 1 : 0];
				end else begin
					highs_nxt[i] = v;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			for (int i = 0; i < tmtd_pkg::TRIM_SLOTS; i++) begin
				lows_q[i]  <= {VBITS{1'b1}};
				highs_q[i] <= '0;
			end
			kind_s2 <= tmtd_pkg::KIND_NONE;
		end else if (en) begin
			if (last) begin
				count_q <= '0;
				sum_q   <= '0;
				for (int i = 0; i < tmtd_pkg::TRIM_SLOTS; i++) begin
					lows_q[i]  <= {VBITS{1'b1}};
					highs_q[i] <= '0;
				end
			end else if (is_sample) begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_nxt;
				lows_q  <= lows_nxt;
				highs_q <= highs_nxt;
			end
			if (is_tick) begin
				kind_s2 <= tmtd_pkg::KIND_TICK;
			end else if (last) begin
				kind_s2 <= tmtd_pkg::KIND_BLOCK;
			end else begin
				kind_s2 <= tmtd_pkg::KIND_NONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && last) begin
			sum_s2   <= sum_nxt;
			lows_s2  <= lows_nxt;
			highs_s2 <= highs_nxt;
		end
	end

	// stage 2: take the trimmed samples off the sum, clamped at zero
	always_comb begin
		total = '0;
		for (int i = 0; i < tmtd_pkg::TRIM_SLOTS; i++) begin
			if (i < TRIM_LOW) begin
				total = total + SUM_W'(lows_s2[i]);
			end
			if (i < TRIM_HIGH) begin
				total = total + SUM_W'(highs_s2[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s3 <= tmtd_pkg::KIND_NONE;
		end else if (en) begin
			kind_s3 <= kind_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && kind_s2 == tmtd_pkg::KIND_BLOCK) begin
			trim_s3 <= (sum_s2 >= total) ? sum_s2 - total : '0;
		end
	end

	// stage 3: divide by the untrimmed count with a reciprocal multiply
	always_comb begin
		prod = PROD_W'(trim_s3) * PROD_W'(RECIP_K);
		quot = prod >> DIV_SH;
		if (DIV_N <= 0) begin
			mean = '0;
		end else if (quot > PROD_W'(tmtd_pkg::MEAN_MAX)) begin
			mean = tmtd_pkg::MEAN_MAX;
		end else begin
			mean = quot[tmtd_pkg::MEAN_W-1:0];
		end
		detected_w = mean > threshold_q;
		report_w   = detected_w && (ticks_q >= holdoff_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			rsp_valid_q <= (kind_s3 == tmtd_pkg::KIND_BLOCK);
			if (kind_s3 == tmtd_pkg::KIND_TICK && ticks_q != tmtd_pkg::TICK_MAX) begin
				ticks_q <= ticks_q + 1'b1;
			end else if (kind_s3 == tmtd_pkg::KIND_BLOCK && report_w) begin
				ticks_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && kind_s3 == tmtd_pkg::KIND_BLOCK) begin
			rsp_data_q.trimmed_mean <= mean;
			rsp_data_q.detected     <= detected_w;
			rsp_data_q.report       <= report_w;
		end
	end

	`TMTD_ASSERT_ALWAYS(a_no_rsp_in_reset, !arst_n |-> !rsp_valid, "result valid during reset")
	`TMTD_ASSERT(a_count_in_block, count_q <= LAST_CNT, "sample count ran past the block end")
	`TMTD_ASSERT(a_report_restarts_holdoff, (en && kind_s3 == tmtd_pkg::KIND_BLOCK && report_w) |=> (ticks_q == '0), "report did not restart the tick count")
	`TMTD_ASSERT(a_report_needs_detect, rsp_valid |-> (!rsp_data.report || (rsp_data.detected && rsp_data.trimmed_mean > threshold_q)), "report without detection")

endmodule
